@@ rtl/fltm_pkg.sv @@
// shared constants for the four-level page table mapper
package fltm_pkg;
    localparam int NUM_FRAMES        = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int STACK_DEPTH       = 64;
    localparam int FRAME_W  = $clog2(NUM_FRAMES);
    localparam int IDX_W    = 9;
    localparam int STORE_AW = FRAME_W + IDX_W;
    localparam int SP_W     = $clog2(STACK_DEPTH);
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ACT_MAP   = 2'd0;
    localparam logic [1:0] ACT_UNMAP = 2'd1;
    localparam logic [1:0] ACT_ALLOC = 2'd2;
    localparam logic [1:0] ACT_FREE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MAPPED = 2'd1;
    localparam logic [1:0] ST_NOMEM  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] PS_1G = 2'd2;
    localparam logic [1:0] PS_2M = 2'd1;

    localparam logic [63:0] ADDR_MASK  = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] LINK_FLAGS = 64'h7;
    localparam logic [11:0] HUGE_FLAG  = 12'h080;
endpackage

@@ rtl/four_level_page_table_mapper_top.sv @@
// four-level page table mapper: walk sequencer, table store and free stack
// free pushes a frame; unmap walks down to the first leaf or huge entry; map walks the levels,
// allocate pops a data frame first, each new table is cleared, then linked; busy meanwhile
// the store has a write port and a separate read port
// after reset a clearing pass zeroes the whole store, busy high
// the result strobe lasts one cycle; the receiver cannot stall
module four_level_page_table_mapper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [47:0] i_virtual_address,
    input  logic [51:0] i_physical_address,
    input  logic [1:0]  i_page_size,
    input  logic [11:0] i_flags,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [30:0] o_freed_bytes
);
    import fltm_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD, S_WAIT, S_CHECK, S_CLEAR, S_LINK, S_DONE
    } t_state;

    t_state r_state;
    logic [5:0]  r_root;
    logic [63:0] r_mem [NUM_FRAMES*ENTRIES_PER_TABLE];
    logic [39:0] r_stack [STACK_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic [STORE_AW-1:0] r_addr;     // slot being examined
    logic [FRAME_W-1:0]  r_new;      // newly popped table
    logic [39:0]         r_link;     // full frame number of the new table
    logic [IDX_W-1:0]    r_clr;
    logic [STORE_AW:0]   r_init;
    logic [1:0]  r_lvl;              // 3 = top level, 0 = leaf
    logic [63:0] r_rdata;
    logic [39:0] r_sdata;
    logic [1:0]  r_act, r_ps;
    logic [47:0] r_va;
    logic [39:0] r_pfn;
    logic [11:0] r_flg;
    logic [1:0]  r_status;
    logic [30:0] r_freed;
    logic        r_strobe;

    // memory port control
    logic        mem_we;
    logic [STORE_AW-1:0] mem_wa;
    logic [63:0] mem_wd;

    assign pready = 1'b1;
    assign prdata = {26'd0, r_root};
    assign busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_freed_bytes = r_freed;

    function automatic logic [IDX_W-1:0] va_idx(input logic [47:0] va, input logic [1:0] lvl);
        logic [IDX_W-1:0] v;
        begin
            case (lvl)
                2'd3:    v = va[47:39];
                2'd2:    v = va[38:30];
                2'd1:    v = va[29:21];
                default: v = va[20:12];
            endcase
            return v;
        end
    endfunction

    logic [FRAME_W-1:0] rd_frame;
    logic               is_leaf;
    logic [63:0]        leaf_val;
    logic [FRAME_W-1:0] pop_fn;
    assign rd_frame = r_rdata[12 +: FRAME_W];
    assign pop_fn   = r_sdata[FRAME_W-1:0];
    assign is_leaf  = (r_lvl == 2'd0) || (r_lvl == 2'd2 && r_ps == PS_1G)
                   || (r_lvl == 2'd1 && r_ps == PS_2M);
    assign leaf_val = {12'd0, r_pfn, (is_leaf && r_lvl != 2'd0) ? (r_flg | HUGE_FLAG) : r_flg};

    // store write select
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = 64'd0;
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_init[STORE_AW-1:0];
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = {r_new, r_clr};
            end
            S_LINK: begin
                mem_we = 1'b1;
                mem_wd = ({24'd0, r_link} << 12) & ADDR_MASK | LINK_FLAGS;
            end
            S_CHECK: begin
                if (r_act == ACT_UNMAP) begin
                    mem_we = (r_rdata != 64'd0) && (r_lvl == 2'd0
                             || (r_lvl != 2'd3 && (r_rdata[7])));
                end else begin
                    mem_we = is_leaf && (r_rdata == 64'd0);
                    mem_wd = leaf_val;
                end
            end
            default: ;
        endcase
    end

    // table store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[r_addr];
    end

    // free stack, top entry always registered in r_sdata
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start && i_action == ACT_FREE && r_cnt < CNT_W'(STACK_DEPTH))
            r_stack[r_cnt[SP_W-1:0]] <= i_physical_address[51:12];
        r_sdata <= r_stack[SP_W'(r_cnt - CNT_W'(1))];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_root <= 6'd0;
        else if (psel && penable && pwrite && pready && paddr == 1'b0) r_root <= pwdata[5:0];
    end

    // walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_DONE);
            case (r_state)
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (r_init == (STORE_AW+1)'(NUM_FRAMES*ENTRIES_PER_TABLE - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_act <= i_action; r_va <= i_virtual_address;
                        r_ps <= (i_action == ACT_ALLOC) ? 2'd0 : i_page_size;
                        r_flg <= i_flags;
                        r_pfn <= i_physical_address[51:12];
                        r_lvl <= 2'd3;
                        r_addr <= {r_root[FRAME_W-1:0], i_virtual_address[47:39]};
                        r_freed <= '0;
                        if (i_action == ACT_FREE) begin
                            r_state <= S_DONE;
                            if (r_cnt >= CNT_W'(STACK_DEPTH)) r_status <= ST_FULL;
                            else begin
                                r_status <= ST_OK;
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end else if (i_action == ACT_ALLOC && r_cnt == '0) begin
                            r_status <= ST_NOMEM; r_state <= S_DONE;
                        end else if (i_action == ACT_ALLOC) begin
                            r_status <= ST_OK;
                            r_cnt <= r_cnt - 1'b1;
                            r_state <= S_WAIT;   // fetch popped frame
                        end else begin
                            r_status <= ST_OK;
                            r_state <= S_RD;
                        end
                    end
                end
                S_WAIT: begin
                    // allocate: popped data frame becomes the leaf address
                    r_pfn <= r_sdata;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_CHECK;  // store read in flight
                S_CHECK: begin
                    if (r_act == ACT_UNMAP) begin
                        if (r_rdata == 64'd0) r_state <= S_DONE;
                        else if (r_lvl == 2'd0) begin
                            r_freed <= 31'd4096; r_state <= S_DONE;
                        end else if (r_lvl != 2'd3 && r_rdata[7]) begin
                            r_freed <= (r_lvl == 2'd2) ? 31'h4000_0000 : 31'd2097152;
                            r_state <= S_DONE;
                        end else begin
                            r_lvl <= r_lvl - 1'b1;
                            r_addr <= {rd_frame, va_idx(r_va, r_lvl - 1'b1)};
                            r_state <= S_RD;
                        end
                    end else if (is_leaf) begin
                        if (r_rdata != 64'd0) r_status <= ST_MAPPED;
                        r_state <= S_DONE;
                    end else if (r_rdata != 64'd0) begin
                        r_lvl <= r_lvl - 1'b1;
                        r_addr <= {rd_frame, va_idx(r_va, r_lvl - 1'b1)};
                        r_state <= S_RD;
                    end else if (r_cnt == '0) begin
                        r_status <= ST_NOMEM; r_state <= S_DONE;
                    end else begin
                        // r_sdata holds top of stack
                        r_cnt <= r_cnt - 1'b1;
                        r_new <= pop_fn;
                        r_link <= r_sdata;
                        r_clr <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_W'(ENTRIES_PER_TABLE - 1)) r_state <= S_LINK;
                end
                S_LINK: begin
                    r_lvl <= r_lvl - 1'b1;
                    r_addr <= {r_new, va_idx(r_va, r_lvl - 1'b1)};
                    r_state <= S_RD;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe longer than one cycle");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH)) else $error("stack count over bound");
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("result while busy");
endmodule

@@ verif/tb.sv @@
// self-checking testbench for the four-level page table mapper top level
`timescale 1ns / 1ps

module tb;
    import fltm_pkg::*;

    localparam int STORE_DEPTH = NUM_FRAMES * ENTRIES_PER_TABLE;
    localparam int WATCH_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] freed_bytes;
    } outcome_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = 1'b0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_action = ACT_MAP;
    logic [47:0] i_virtual_address = 48'd0;
    logic [51:0] i_physical_address = 52'd0;
    logic [1:0]  i_page_size = 2'd0;
    logic [11:0] i_flags = 12'd0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [30:0] o_freed_bytes;

    four_level_page_table_mapper_top DUT (.*);

    // clock
    always #5 i_clk = ~i_clk;

    // shadow of the page tables, the free frame stack and the root register
    logic [63:0] page_tables [0:STORE_DEPTH-1];
    logic [39:0] frame_stack [0:STACK_DEPTH-1];
    int          frames_held;
    logic [5:0]  root_sel;

    outcome_t    pending_outcomes [$];
    int          mismatches;
    int          requests_sent;
    int          results_seen;
    int          status_hits [4];
    int          idle_pct;
    bit          start_hi;
    int          quiet_cycles;
    logic [47:0] va_pool [8];

    function automatic int slot_of(int frame, logic [47:0] va, int shift);
        return frame * ENTRIES_PER_TABLE + int'((va >> shift) & 48'h1ff);
    endfunction

    function automatic bit take_frame(output logic [39:0] frame_no);
        frame_no = '0;
        if (frames_held == 0) return 1'b0;
        frames_held--;
        frame_no = frame_stack[frames_held];
        return 1'b1;
    endfunction

    // follow the link in a parent entry, or pop, clear and link a new table
    function automatic bit reach_table(int parent, output int frame);
        logic [39:0] fn;
        frame = 0;
        if (page_tables[parent] != 64'd0) begin
            frame = int'(page_tables[parent][17:12]);
            return 1'b1;
        end
        if (!take_frame(fn)) return 1'b0;
        frame = int'(fn[5:0]);
        for (int i = 0; i < ENTRIES_PER_TABLE; i++)
            page_tables[frame * ENTRIES_PER_TABLE + i] = 64'd0;
        page_tables[parent] = {12'd0, fn, 12'd0} | LINK_FLAGS;
        return 1'b1;
    endfunction

    function automatic logic [1:0] map_page(logic [47:0] va, logic [51:0] pa,
                                            logic [1:0] ps, logic [11:0] fl);
        int f3, f2, f1, s;
        if (!reach_table(slot_of(int'(root_sel), va, 39), f3)) return ST_NOMEM;
        s = slot_of(f3, va, 30);
        if (ps == PS_1G) begin
            if (page_tables[s] != 64'd0) return ST_MAPPED;
            page_tables[s] = {12'd0, pa[51:12], fl | HUGE_FLAG};
            return ST_OK;
        end
        if (!reach_table(s, f2)) return ST_NOMEM;
        s = slot_of(f2, va, 21);
        if (ps == PS_2M) begin
            if (page_tables[s] != 64'd0) return ST_MAPPED;
            page_tables[s] = {12'd0, pa[51:12], fl | HUGE_FLAG};
            return ST_OK;
        end
        if (!reach_table(s, f1)) return ST_NOMEM;
        s = slot_of(f1, va, 12);
        if (page_tables[s] != 64'd0) return ST_MAPPED;
        page_tables[s] = {12'd0, pa[51:12], fl};
        return ST_OK;
    endfunction

    function automatic logic [30:0] unmap_page(logic [47:0] va);
        logic [63:0] e;
        int s;
        s = slot_of(int'(root_sel), va, 39);
        e = page_tables[s];
        if (e == 64'd0) return 31'd0;
        s = slot_of(int'(e[17:12]), va, 30);
        e = page_tables[s];
        if (e == 64'd0) return 31'd0;
        if (e[7]) begin
            page_tables[s] = 64'd0;
            return 31'd1 << 30;
        end
        s = slot_of(int'(e[17:12]), va, 21);
        e = page_tables[s];
        if (e == 64'd0) return 31'd0;
        if (e[7]) begin
            page_tables[s] = 64'd0;
            return 31'd1 << 21;
        end
        s = slot_of(int'(e[17:12]), va, 12);
        if (page_tables[s] == 64'd0) return 31'd0;
        page_tables[s] = 64'd0;
        return 31'd1 << 12;
    endfunction

    function automatic outcome_t mapper_outcome(logic [1:0] act, logic [47:0] va,
                                                logic [51:0] pa, logic [1:0] ps,
                                                logic [11:0] fl);
        outcome_t r;
        logic [39:0] fn;
        r = '0;
        case (act)
            ACT_MAP: r.status = map_page(va, pa, ps, fl);
            ACT_UNMAP: r.freed_bytes = unmap_page(va);
            ACT_ALLOC: begin
                if (!take_frame(fn)) r.status = ST_NOMEM;
                else r.status = map_page(va, {fn, 12'd0}, 2'd0, fl);
            end
            default: begin
                if (frames_held >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    frame_stack[frames_held] = pa[51:12];
                    frames_held++;
                end
            end
        endcase
        return r;
    endfunction

    // send one request and record what it should produce
    task automatic send_request(logic [1:0] act, logic [47:0] va, logic [51:0] pa,
                                logic [1:0] ps, logic [11:0] fl);
        i_action <= act;
        i_virtual_address <= va;
        i_physical_address <= pa;
        i_page_size <= ps;
        i_flags <= fl;
        start <= 1'b1;
        start_hi = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_outcomes.push_back(mapper_outcome(act, va, pa, ps, fl));
        requests_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            start_hi = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every result is back and the block is idle
    task automatic drain();
        if (start_hi) begin
            start <= 1'b0;
            start_hi = 1'b0;
        end
        @(posedge i_clk);
        while (pending_outcomes.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_root(logic [5:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 1'b0;
        pwdata <= {26'($urandom_range(32'h03ff_ffff, 0)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        root_sel = value;
        @(posedge i_clk);
    endtask

    function automatic logic [51:0] rand_pa();
        return {20'($urandom_range(20'hfffff, 0)), $urandom};
    endfunction

    function automatic logic [47:0] pool_va();
        logic [47:0] va;
        va = va_pool[$urandom_range(7)];
        // mostly vary only the low levels so walks share tables
        case ($urandom_range(3))
            0: va[20:0] = 21'($urandom);
            1: va[29:12] = 18'($urandom);
            2: va[38:21] = 18'($urandom);
            default: va = {16'($urandom_range(16'hffff, 0)), $urandom};
        endcase
        return va;
    endfunction

    // extremes of the fields, each action, each page size and special case
    task automatic test_directed();
        send_request(ACT_MAP, 48'h0, 52'h0, 2'd0, 12'h0);           // empty stack
        send_request(ACT_ALLOC, 48'h1000, 52'h0, 2'd0, 12'h1);      // empty stack
        send_request(ACT_FREE, 48'h0, {52{1'b1}}, 2'd0, 12'hfff);
        send_request(ACT_FREE, 48'hffff_ffff_ffff, 52'h0, 2'd3, 12'h0);
        send_request(ACT_FREE, 48'h0, 52'h2_0000, 2'd0, 12'h0);
        send_request(ACT_FREE, 48'h0, 52'h5_0fff, 2'd0, 12'h0);
        send_request(ACT_MAP, {48{1'b1}}, {52{1'b1}}, 2'd0, 12'hfff);  // 4 KiB
        send_request(ACT_MAP, {48{1'b1}}, 52'h1234_5000, 2'd0, 12'h3);  // already mapped
        send_request(ACT_UNMAP, {48{1'b1}}, 52'h0, 2'd0, 12'h0);
        send_request(ACT_UNMAP, {48{1'b1}}, 52'h0, 2'd0, 12'h0);        // nothing there
        send_request(ACT_MAP, 48'h0000_0020_0000, 52'hab_cd00_0000, PS_2M, 12'h7);
        send_request(ACT_MAP, 48'h0000_4000_0000, 52'h8000_0000, PS_1G, 12'h803);
        send_request(ACT_MAP, 48'h0000_4000_0000, 52'h8000_0000, PS_1G, 12'h0);
        send_request(ACT_UNMAP, 48'h0000_0020_0000, 52'h0, 2'd0, 12'h0);
        send_request(ACT_UNMAP, 48'h0000_4000_0000, 52'h0, 2'd0, 12'h0);
        send_request(ACT_FREE, 48'h0, 52'h7_f000, 2'd0, 12'h0);
        send_request(ACT_FREE, 48'h0, 52'h8_f000, 2'd0, 12'h0);
        send_request(ACT_MAP, 48'h8000_0000_0000, 52'h0, 2'd3, 12'h555); // size three
        send_request(ACT_ALLOC, 48'h8000_0000_1000, 52'h0, 2'd1, 12'haaa);
        send_request(ACT_ALLOC, 48'h8000_0000_1000, 52'h0, 2'd0, 12'h1);  // frame lost
        send_request(ACT_UNMAP, 48'h8000_0000_1000, 52'h0, 2'd0, 12'h0);
        send_request(ACT_UNMAP, 48'h1234_5678_9abc, 52'h0, 2'd0, 12'h0);  // no table
        drain();
    endtask

    // fill the free stack past its bound, then use it up
    task automatic test_stack_bound();
        for (int i = 0; i < STACK_DEPTH + 3; i++)
            send_request(ACT_FREE, pool_va(), rand_pa(), 2'($urandom_range(3)),
                         12'($urandom));
        for (int i = 0; i < 40; i++)
            send_request(ACT_ALLOC, {16'($urandom_range(16'hffff, 0)), $urandom}, 52'h0,
                         2'd0, 12'($urandom));
        drain();
    endtask

    // random traffic, mostly frees, maps and unmaps over shared addresses
    task automatic test_random(int count, int gap_pct);
        int pick;
        idle_pct = gap_pct;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (i == count / 2) drain();
            if (pick < 30)
                send_request(ACT_FREE, pool_va(), rand_pa(), 2'($urandom_range(3)),
                             12'($urandom));
            else if (pick < 58)
                send_request(ACT_MAP, pool_va(), rand_pa(), 2'($urandom_range(3)),
                             12'($urandom));
            else if (pick < 72)
                send_request(ACT_ALLOC, pool_va(), rand_pa(), 2'($urandom_range(3)),
                             12'($urandom));
            else
                send_request(ACT_UNMAP, pool_va(), rand_pa(), 2'($urandom_range(3)),
                             12'($urandom));
        end
        drain();
    endtask

    // result check
    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d freed %0d",
                             o_status, o_freed_bytes);
            end else begin
                want = pending_outcomes.pop_front();
                status_hits[o_status]++;
                if (o_status !== want.status || o_freed_bytes !== want.freed_bytes) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, freed exp %0d got %0d",
                                 want.status, o_status, want.freed_bytes, o_freed_bytes);
                end
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) page_tables[i] = 64'd0;
        for (int i = 0; i < STACK_DEPTH; i++) frame_stack[i] = 40'd0;
        frames_held = 0;
        root_sel = 6'd0;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        start_hi = 1'b0;
        for (int i = 0; i < 4; i++) status_hits[i] = 0;
        for (int i = 0; i < 8; i++)
            va_pool[i] = {16'($urandom_range(16'hffff, 0)), $urandom};

        // reset, then let the clearing pass finish
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        write_root(6'd0);
        test_directed();
        write_root(6'd63);
        test_stack_bound();
        write_root(6'd63);
        test_random(120, 0);
        write_root(6'($urandom));
        test_random(120, 77);
        write_root(6'd0);
        test_random(120, 28);
        write_root(6'($urandom));
        test_random(120, 0);

        $display("requests %0d, results %0d: maps, unmaps, allocations, frees",
                 requests_sent, results_seen);
        $display("status counts ok %0d mapped %0d nomem %0d full %0d, mismatches %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
